FILE: rtl/core/wrp_pkg.sv
// ----------------------------------------------------------------------------
// wrp_pkg
// Shared types and codes for the weighted random backend picker.
// ----------------------------------------------------------------------------
package wrp_pkg;

  localparam int unsigned DefaultSlots = 16;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned DrawW        = 64;
  localparam int unsigned WeightW      = 16;
  localparam int unsigned SlotPortW    = 4;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_CONNECT = 2'd1,
    CMD_REBUILD = 2'd2,
    CMD_PICK    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_CHOSEN  = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_NO_LINK = 2'd2,
    STATUS_UNUSED  = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e                 op;
    logic [SlotPortW-1:0] slot;
    logic [WeightW-1:0]   weight;
    logic                 present;
    logic                 up;
    logic [DrawW-1:0]     draw;
  } cmd_t;

endpackage

FILE: rtl/core/wrp_front.sv
// ----------------------------------------------------------------------------
// wrp_front
// Command intake: drops out-of-range slot commands and queues the rest.
// ----------------------------------------------------------------------------
module wrp_front #(
  parameter int unsigned SLOTS = wrp_pkg::DefaultSlots
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  wrp_pkg::cmd_t cmd,
  output logic          busy,
  output logic          q_valid,
  input  logic          q_ready,
  output wrp_pkg::cmd_t q_head
);

  localparam int unsigned PtrW = $clog2(wrp_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(wrp_pkg::QueueDepth + 1);

  wrp_pkg::cmd_t    fifo [wrp_pkg::QueueDepth];
  logic [PtrW-1:0]  wptr;
  logic [PtrW-1:0]  rptr;
  logic [CntW-1:0]  count;
  logic             accept;
  logic             keep;
  logic             push;
  logic             pop;

  // Classify: slot commands outside the table are dropped
  always_comb begin
    keep = 1'b1;
    if ((cmd.op == wrp_pkg::CMD_WRITE) || (cmd.op == wrp_pkg::CMD_CONNECT)) begin
      keep = (32'(cmd.slot) < SLOTS);
    end
  end

  assign busy    = (count == CntW'(wrp_pkg::QueueDepth));
  assign accept  = start && !busy;
  assign push    = accept && keep;
  assign q_valid = (count != '0);
  assign pop     = q_valid && q_ready;
  assign q_head  = fifo[rptr];

  // Store queued commands
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= cmd;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PtrW'(wrp_pkg::QueueDepth - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PtrW'(wrp_pkg::QueueDepth - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + CntW'(push) - CntW'(pop);
    end
  end

endmodule

FILE: rtl/core/wrp_back.sv
// ----------------------------------------------------------------------------
// wrp_back
// Command engine: slot table, member list rebuild, modulo and member scan.
// ----------------------------------------------------------------------------
module wrp_back #(
  parameter int unsigned SLOTS = wrp_pkg::DefaultSlots
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  wrp_pkg::cmd_t                   q_head,
  output logic                            result_valid,
  output logic [1:0]                      status,
  output logic [wrp_pkg::SlotPortW-1:0]   chosen_slot
);

  localparam int unsigned SlotW = $clog2(SLOTS);
  localparam int unsigned CntW  = $clog2(SLOTS + 1);
  localparam int unsigned SumW  = wrp_pkg::WeightW + SlotW;
  localparam int unsigned BitW  = $clog2(wrp_pkg::DrawW);

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [SumW-1:0]  sum;
  } member_t;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_REBUILD  = 7'b0000010,
    ST_DIVIDE   = 7'b0000100,
    ST_FIND_RD  = 7'b0001000,
    ST_FIND_CHK = 7'b0010000,
    ST_SCAN_RD  = 7'b0100000,
    ST_SCAN_CHK = 7'b1000000
  } state_t;

  state_t                      state;
  logic [wrp_pkg::WeightW-1:0] weight_table [SLOTS];
  logic [SLOTS-1:0]            present_bits;
  logic [SLOTS-1:0]            connected_bits;
  member_t                     members [SLOTS];
  member_t                     rd;
  logic [CntW-1:0]             member_count;
  logic [SumW-1:0]             total;
  logic [SlotW-1:0]            idx;
  logic [CntW-1:0]             scan_n;
  logic [BitW-1:0]             bit_cnt;
  logic [wrp_pkg::DrawW-1:0]   draw_sh;
  logic [SumW:0]               rem;
  logic [SumW:0]               rem_shift;
  logic [SumW:0]               rem_next;
  logic [SumW-1:0]             total_next;
  logic                        is_member;
  logic                        mem_we;
  logic [SlotW-1:0]            head_slot;
  logic                        last_idx;

  assign q_ready    = (state == ST_IDLE);
  assign head_slot  = SlotW'(q_head.slot);
  assign is_member  = present_bits[idx] && connected_bits[idx];
  assign total_next = total + SumW'(weight_table[idx]);
  assign mem_we     = (state == ST_REBUILD) && is_member;
  assign last_idx   = (CntW'(idx) + 1'b1 == member_count);

  // One restoring step of the modulo
  always_comb begin
    rem_shift = {rem[SumW-1:0], draw_sh[wrp_pkg::DrawW-1]};
    rem_next  = rem_shift;
    if (rem_shift >= {1'b0, total}) begin
      rem_next = rem_shift - {1'b0, total};
    end
  end

  // Member list memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      members[SlotW'(member_count)] <= '{slot: idx, sum: total_next};
    end
    rd <= members[idx];
  end

  // Slot table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        weight_table[i] <= '0;
      end
      present_bits   <= '0;
      connected_bits <= '0;
    end else if (q_valid && (state == ST_IDLE)) begin
      if (q_head.op == wrp_pkg::CMD_WRITE) begin
        weight_table[head_slot] <= q_head.weight;
        present_bits[head_slot] <= q_head.present;
        connected_bits[head_slot] <= q_head.up;
      end else if (q_head.op == wrp_pkg::CMD_CONNECT) begin
        connected_bits[head_slot] <= q_head.up;
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      member_count <= '0;
      total        <= '0;
      result_valid <= 1'b0;
      status       <= wrp_pkg::STATUS_EMPTY;
      chosen_slot  <= '0;
      idx          <= '0;
      scan_n       <= '0;
      bit_cnt      <= '0;
      rem          <= '0;
      draw_sh      <= '0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            unique case (q_head.op)
              wrp_pkg::CMD_REBUILD: begin
                member_count <= '0;
                total        <= '0;
                idx          <= '0;
                state        <= ST_REBUILD;
              end
              wrp_pkg::CMD_PICK: begin
                if ((member_count == '0) || (total == '0)) begin
                  result_valid <= 1'b1;
                  status       <= wrp_pkg::STATUS_EMPTY;
                  chosen_slot  <= '0;
                end else begin
                  draw_sh <= q_head.draw;
                  rem     <= '0;
                  bit_cnt <= '0;
                  state   <= ST_DIVIDE;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_REBUILD: begin
          if (is_member) begin
            total        <= total_next;
            member_count <= member_count + 1'b1;
          end
          if (idx == SlotW'(SLOTS - 1)) begin
            state <= ST_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_DIVIDE: begin
          rem     <= rem_next;
          draw_sh <= draw_sh << 1;
          bit_cnt <= bit_cnt + 1'b1;
          if (bit_cnt == BitW'(wrp_pkg::DrawW - 1)) begin
            idx   <= '0;
            state <= ST_FIND_RD;
          end
        end
        ST_FIND_RD: begin
          state <= ST_FIND_CHK;
        end
        ST_FIND_CHK: begin
          if (({1'b0, rd.sum} > rem) || last_idx) begin
            scan_n <= '0;
            state  <= ST_SCAN_RD;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_FIND_RD;
          end
        end
        ST_SCAN_RD: begin
          state <= ST_SCAN_CHK;
        end
        ST_SCAN_CHK: begin
          if (connected_bits[rd.slot]) begin
            result_valid <= 1'b1;
            status       <= wrp_pkg::STATUS_CHOSEN;
            chosen_slot  <= wrp_pkg::SlotPortW'(rd.slot);
            state        <= ST_IDLE;
          end else if (scan_n + 1'b1 == member_count) begin
            result_valid <= 1'b1;
            status       <= wrp_pkg::STATUS_NO_LINK;
            chosen_slot  <= '0;
            state        <= ST_IDLE;
          end else begin
            scan_n <= scan_n + 1'b1;
            idx    <= last_idx ? '0 : idx + 1'b1;
            state  <= ST_SCAN_RD;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/weighted_random_backend_picker.sv
// ----------------------------------------------------------------------------
// weighted_random_backend_picker
// Weighted backend selection over prefix sums of connected member weights.
// ----------------------------------------------------------------------------
// channel   signals                                          direction
// command   start, busy (out), command, slot, slot_weight,   in
//           slot_present, link_up, draw
// result    result_valid, status, chosen_slot                out
//
// Write and connect update the slot table; a rebuild walks every slot.
// A pick answers at once when empty, else takes 64 modulo steps (one draw
// bit a cycle) and a read and check per member in the find and scan passes.
// A two-entry command queue raises busy when full. rst is synchronous.
// The receiver cannot stall: result_valid marks each result for one cycle.
// ----------------------------------------------------------------------------
module weighted_random_backend_picker #(
  parameter int unsigned SLOTS = wrp_pkg::DefaultSlots
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    command,
  input  logic [wrp_pkg::SlotPortW-1:0] slot,
  input  logic [wrp_pkg::WeightW-1:0]   slot_weight,
  input  logic                          slot_present,
  input  logic                          link_up,
  input  logic [wrp_pkg::DrawW-1:0]     draw,
  output logic                          result_valid,
  output logic [1:0]                    status,
  output logic [wrp_pkg::SlotPortW-1:0] chosen_slot
);

  wrp_pkg::cmd_t cmd;
  wrp_pkg::cmd_t q_head;
  logic          q_valid;
  logic          q_ready;

  assign cmd = '{op: wrp_pkg::cmd_e'(command), slot: slot, weight: slot_weight,
                 present: slot_present, up: link_up, draw: draw};

  wrp_front #(.SLOTS(SLOTS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd),
    .busy    (busy),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_head  (q_head)
  );

  wrp_back #(.SLOTS(SLOTS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_head       (q_head),
    .result_valid (result_valid),
    .status       (status),
    .chosen_slot  (chosen_slot)
  );

  // Result fields are known whenever the strobe is up
  a_known: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !$isunknown({status, chosen_slot})) else $error("unknown result");

  // Only chosen results carry a slot
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (status != wrp_pkg::STATUS_CHOSEN)) |-> (chosen_slot == '0))
    else $error("slot set without a choice");

  // Status code stays in range
  a_status: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status != wrp_pkg::STATUS_UNUSED)) else $error("bad status");

endmodule
